/* rtl/bsp_pkg.sv */
// ============================================================================
// bsp_pkg
// Shared types and constants of the BLDC speed PID block.
// ============================================================================
package bsp_pkg;

    localparam int GAIN_FRAC_BITS  = 8;
    localparam int SPEED_BITS      = 16;
    localparam int DUTY_FULL_SCALE = 4096;
    localparam int DUTY_BITS       = 13;
    localparam int ERR_BITS        = SPEED_BITS + 1;
    localparam int PERIOD_BITS     = 24;
    localparam int DVD_BITS        = 32;
    localparam int DVS_BITS        = PERIOD_BITS;
    localparam int CNT_BITS        = $clog2(DVD_BITS);
    localparam int ACC_BITS        = 36;
    localparam int SCALED_BITS     = SPEED_BITS + GAIN_FRAC_BITS;
    localparam int DUTY_SHIFT      = $clog2(DUTY_FULL_SCALE) - GAIN_FRAC_BITS;

    typedef enum logic [2:0] {
        REG_PROP_GAIN     = 3'd0,
        REG_INTEGRAL_GAIN = 3'd1,
        REG_DERIV_GAIN    = 3'd2,
        REG_SPEED_NUM     = 3'd3,
        REG_DUTY_SLOPE    = 3'd4,
        REG_DUTY_OFFSET   = 3'd5,
        REG_SPEED_LIMIT   = 3'd6,
        REG_PROP_ON_ERROR = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic                start;
        logic [DVD_BITS-1:0] dividend;
        logic [DVS_BITS-1:0] divisor;
    } div_req_t;

endpackage

/* rtl/bsp_div.sv */
// ============================================================================
// bsp_div
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
module bsp_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bsp_pkg::div_req_t            req,
    output logic                         done,
    output logic [bsp_pkg::DVD_BITS-1:0] quotient
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [bsp_pkg::CNT_BITS-1:0]  cnt_reg;
    logic [bsp_pkg::DVD_BITS-1:0]  quo_reg;
    logic [bsp_pkg::DVS_BITS-1:0]  rem_reg;
    logic [bsp_pkg::DVS_BITS-1:0]  dvs_reg;
    logic [bsp_pkg::DVS_BITS:0]    rem_shift;
    logic [bsp_pkg::DVS_BITS+1:0]  trial;

    assign rem_shift = {rem_reg, quo_reg[bsp_pkg::DVD_BITS-1]};
    assign trial     = {1'b0, rem_shift} - {2'b00, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == bsp_pkg::CNT_BITS'(bsp_pkg::DVD_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[bsp_pkg::DVS_BITS+1])
            begin
                rem_reg <= trial[bsp_pkg::DVS_BITS-1:0];
                quo_reg <= {quo_reg[bsp_pkg::DVD_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift[bsp_pkg::DVS_BITS-1:0];
                quo_reg <= {quo_reg[bsp_pkg::DVD_BITS-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/bldc_speed_pid_unit.sv */
// ============================================================================
// bldc_speed_pid_unit
// Speed PID for a brushless motor, one beat per commutation event.
// ============================================================================
// Each input beat carries the commutation period in microseconds and the
// target speed. The unit turns the period into a speed with the shared
// divider, runs the PI loop with derivative on measurement through one
// 17x17 multiplier over four steps, and maps the clamped output to a PWM
// duty with a second pass of the same divider.
// The result beat follows the speed division, the controller steps, the
// duty division (skipped when the duty is zero) and the load of the
// output register. One event is in work at a time; s_axis_tready is
// high only while the unit is idle.
// The result beat sits in an output register. While the receiver stalls
// the unit may take the next event, and holds its own result until the
// register is free.
// Reset clears the previous speed, the integrator and the output valid, and
// loads register defaults. The user writes configuration over APB only while
// the unit is idle; this is not enforced. Register i sits at byte address 4*i.
// ============================================================================
module bldc_speed_pid_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // period_us[23:0], target_speed[39:24]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // duty[12:0], measured_speed[28:13],
                                       // speed_error[45:29], zero[47:46]
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SPEED,
        S_ERR,
        S_MUL,
        S_ACC,
        S_CLAMP_I,
        S_CLAMP_O,
        S_DUTY,
        S_OUT
    } state_t;

    localparam int SB = bsp_pkg::SPEED_BITS;
    localparam int EB = bsp_pkg::ERR_BITS;
    localparam int AB = bsp_pkg::ACC_BITS;
    localparam int QB = bsp_pkg::SCALED_BITS;
    localparam int PB = 2 * EB;

    // configuration
    logic [15:0] prop_gain_reg;
    logic [15:0] integral_gain_reg;
    logic [15:0] deriv_gain_reg;
    logic [31:0] speed_num_reg;
    logic [15:0] duty_slope_reg;
    logic [15:0] duty_offset_reg;
    logic [15:0] speed_limit_reg;
    logic        prop_on_error_reg;
    logic        cfg_wr;
    bsp_pkg::reg_idx_t cfg_idx;

    // datapath
    state_t                       state_reg;
    logic [1:0]                   step_reg;
    bsp_pkg::div_req_t            div_req_reg;
    logic                         div_done;
    logic [bsp_pkg::DVD_BITS-1:0] div_quo;
    logic [SB-1:0]                target_reg;
    logic [SB-1:0]                speed_reg;
    logic [SB-1:0]                prev_speed_reg;
    logic signed [EB-1:0]         err_reg;
    logic signed [EB-1:0]         dmeas_reg;
    logic [QB-1:0]                integ_reg;
    logic signed [AB-1:0]         acc_reg;
    logic signed [PB-1:0]         prod_reg;
    logic [QB-1:0]                outv_reg;
    logic [bsp_pkg::DUTY_BITS-1:0] duty_reg;
    logic                         m_valid_reg;
    logic [47:0]                  m_data_reg;

    logic signed [EB-1:0]         mul_a;
    logic signed [EB-1:0]         mul_b;
    logic                         mul_sub;
    logic signed [AB-1:0]         acc_sum;
    logic [QB-1:0]                lim;
    logic [QB-1:0]                acc_clamped;
    logic signed [QB+1:0]         diff;
    logic [15:0]                  slope_eff;
    logic [SB-1:0]                speed_sat;
    logic [bsp_pkg::DUTY_BITS-1:0] duty_sat;
    logic                         in_beat;

    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = bsp_pkg::reg_idx_t'(paddr[4:2]);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg     <= '0;
            integral_gain_reg <= '0;
            deriv_gain_reg    <= '0;
            speed_num_reg     <= 32'd30000000;
            duty_slope_reg    <= 16'd1;
            duty_offset_reg   <= '0;
            speed_limit_reg   <= 16'hFFFF;
            prop_on_error_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                bsp_pkg::REG_PROP_GAIN:     prop_gain_reg     <= pwdata[15:0];
                bsp_pkg::REG_INTEGRAL_GAIN: integral_gain_reg <= pwdata[15:0];
                bsp_pkg::REG_DERIV_GAIN:    deriv_gain_reg    <= pwdata[15:0];
                bsp_pkg::REG_SPEED_NUM:     speed_num_reg     <= pwdata;
                bsp_pkg::REG_DUTY_SLOPE:    duty_slope_reg    <= pwdata[15:0];
                bsp_pkg::REG_DUTY_OFFSET:   duty_offset_reg   <= pwdata[15:0];
                bsp_pkg::REG_SPEED_LIMIT:   speed_limit_reg   <= pwdata[15:0];
                bsp_pkg::REG_PROP_ON_ERROR: prop_on_error_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            bsp_pkg::REG_PROP_GAIN:     prdata = {16'd0, prop_gain_reg};
            bsp_pkg::REG_INTEGRAL_GAIN: prdata = {16'd0, integral_gain_reg};
            bsp_pkg::REG_DERIV_GAIN:    prdata = {16'd0, deriv_gain_reg};
            bsp_pkg::REG_SPEED_NUM:     prdata = speed_num_reg;
            bsp_pkg::REG_DUTY_SLOPE:    prdata = {16'd0, duty_slope_reg};
            bsp_pkg::REG_DUTY_OFFSET:   prdata = {16'd0, duty_offset_reg};
            bsp_pkg::REG_SPEED_LIMIT:   prdata = {16'd0, speed_limit_reg};
            bsp_pkg::REG_PROP_ON_ERROR: prdata = {31'd0, prop_on_error_reg};
            default:                    prdata = '0;
        endcase
    end

    bsp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // multiplier operand select per step
    always_comb
    begin
        case (step_reg)
            2'd0:
            begin
                mul_a   = {1'b0, integral_gain_reg};
                mul_b   = err_reg;
                mul_sub = 1'b0;
            end
            2'd1:
            begin
                mul_a   = prop_on_error_reg ? '0 : {1'b0, prop_gain_reg};
                mul_b   = dmeas_reg;
                mul_sub = 1'b1;
            end
            2'd2:
            begin
                mul_a   = prop_on_error_reg ? {1'b0, prop_gain_reg} : '0;
                mul_b   = err_reg;
                mul_sub = 1'b0;
            end
            default:
            begin
                mul_a   = {1'b0, deriv_gain_reg};
                mul_b   = dmeas_reg;
                mul_sub = 1'b1;
            end
        endcase
    end

    assign acc_sum = mul_sub ? acc_reg - AB'(prod_reg) : acc_reg + AB'(prod_reg);
    assign lim     = {speed_limit_reg, {bsp_pkg::GAIN_FRAC_BITS{1'b0}}};

    always_comb
    begin
        if (acc_reg[AB-1])
            acc_clamped = '0;
        else if (acc_reg > $signed({{(AB-QB){1'b0}}, lim}))
            acc_clamped = lim;
        else
            acc_clamped = acc_reg[QB-1:0];
    end

    assign diff = $signed({2'b00, outv_reg})
                - $signed({2'b00, duty_offset_reg, {bsp_pkg::GAIN_FRAC_BITS{1'b0}}});
    assign slope_eff = (duty_slope_reg == '0) ? 16'd1 : duty_slope_reg;
    assign speed_sat = (div_quo[bsp_pkg::DVD_BITS-1:SB] != '0) ? {SB{1'b1}}
                                                               : div_quo[SB-1:0];
    assign duty_sat  = (div_quo > bsp_pkg::DVD_BITS'(bsp_pkg::DUTY_FULL_SCALE))
                     ? bsp_pkg::DUTY_BITS'(bsp_pkg::DUTY_FULL_SCALE)
                     : div_quo[bsp_pkg::DUTY_BITS-1:0];
    assign in_beat   = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_reg       <= '0;
            div_req_reg    <= '0;
            target_reg     <= '0;
            speed_reg      <= '0;
            prev_speed_reg <= '0;
            err_reg        <= '0;
            dmeas_reg      <= '0;
            integ_reg      <= '0;
            acc_reg        <= '0;
            prod_reg       <= '0;
            outv_reg       <= '0;
            duty_reg       <= '0;
            m_valid_reg    <= 1'b0;
            m_data_reg     <= '0;
        end
        else
        begin
            div_req_reg.start <= 1'b0;
            if (m_axis_tready)
                m_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_beat)
                    begin
                        target_reg           <= s_axis_tdata[39:24];
                        div_req_reg.start    <= 1'b1;
                        div_req_reg.dividend <= speed_num_reg;
                        div_req_reg.divisor  <= s_axis_tdata[23:0];
                        state_reg            <= S_SPEED;
                    end
                end
                S_SPEED:
                begin
                    if (div_done)
                    begin
                        speed_reg <= speed_sat;
                        state_reg <= S_ERR;
                    end
                end
                S_ERR:
                begin
                    err_reg        <= $signed({1'b0, target_reg}) - $signed({1'b0, speed_reg});
                    dmeas_reg      <= $signed({1'b0, speed_reg})
                                    - $signed({1'b0, prev_speed_reg});
                    prev_speed_reg <= speed_reg;
                    acc_reg        <= AB'({1'b0, integ_reg});
                    step_reg       <= 2'd0;
                    state_reg      <= S_MUL;
                end
                S_MUL:
                begin
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    acc_reg  <= acc_sum;
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == 2'd1)
                        state_reg <= S_CLAMP_I;
                    else if (step_reg == 2'd3)
                        state_reg <= S_CLAMP_O;
                    else
                        state_reg <= S_MUL;
                end
                S_CLAMP_I:
                begin
                    integ_reg <= acc_clamped;
                    acc_reg   <= AB'({1'b0, acc_clamped});
                    state_reg <= S_MUL;
                end
                S_CLAMP_O:
                begin
                    outv_reg  <= acc_clamped;
                    state_reg <= S_DUTY;
                end
                S_DUTY:
                begin
                    if (!div_req_reg.start && !div_done && (diff <= 0))
                    begin
                        duty_reg  <= '0;
                        state_reg <= S_OUT;
                    end
                    else if (!div_req_reg.start && !div_done && step_reg == 2'd0)
                    begin
                        div_req_reg.start    <= 1'b1;
                        div_req_reg.dividend <= bsp_pkg::DVD_BITS'(
                                                {diff[QB-1:0], {bsp_pkg::DUTY_SHIFT{1'b0}}});
                        div_req_reg.divisor  <= bsp_pkg::DVS_BITS'(slope_eff);
                        step_reg             <= 2'd1;
                    end
                    else if (div_done)
                    begin
                        duty_reg  <= duty_sat;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!m_valid_reg || m_axis_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {2'b00, err_reg, speed_reg, duty_reg};
                        step_reg    <= '0;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule
